// File: hdl/huffman_tree_build_encode_defines.svh
// ----------------------------------------------------------------------------
// Huffman tree build/encode assertion macros
// Shared assertion helpers; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BUILD_ENCODE_DEFINES_SVH
`define HUFFMAN_TREE_BUILD_ENCODE_DEFINES_SVH
`ifndef SYNTH
`define HTBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HTBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HTBE_ASSERT_IMPL(lbl, ante, cons)
`define HTBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/htbe_pkg.sv
// ----------------------------------------------------------------------------
// htbe_pkg
// Types and constants for the Huffman tree build/encode block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package htbe_pkg;
  localparam int unsigned SYMBOLS         = 256;
  localparam int unsigned COUNT_WIDTH     = 32;
  localparam int unsigned MAX_CODE_LENGTH = 64;
  localparam int unsigned WEIGHT_WIDTH    = 40;
  localparam int unsigned NODE_TOTAL      = 2 * SYMBOLS - 1;
  localparam int unsigned NODE_W          = $clog2(NODE_TOTAL);
  localparam int unsigned SLOT_W          = $clog2(SYMBOLS);
  localparam int unsigned IDX_W           = SLOT_W + 1;
  localparam int unsigned ROOT_NODE       = 2 * SYMBOLS - 2;
  localparam int unsigned BITS_W          = 64;
  localparam int unsigned LEN_W           = 7;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_TREE  = 2'd1,
    ST_ZERO_CNT = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_C_RD, S_C_WR, S_I_RD, S_I_WR, S_S_RD, S_S_CMP,
    S_M_LO, S_M_NX, S_ROOT, S_E_CNT, S_E_CHK0, S_E_CHK, S_E_STEP, S_RES
  } state_e;

  typedef struct packed {
    logic    clr_wr;
    logic    take_in;
    logic    cnt_rd;
    logic    cnt_wr;
    logic    init_start;
    logic    init_rd;
    logic    init_wr;
    logic    scan_rd;
    logic    scan_cmp;
    logic    merge_lo;
    logic    merge_nx;
    logic    set_root;
    logic    enc_start;
    logic    enc_rd;
    logic    enc_step;
    logic    res_set;
    status_e res_st;
    logic    res_load;
  } htbe_cmd_t;

  typedef struct packed {
    op_e  op;
    logic tree_ready;
    logic sym_ok;
    logic cnt_zero;
    logic clr_last;
    logic init_last;
    logic scan_last;
    logic size_two;
    logic at_root;
    logic len_full;
    logic out_free;
  } htbe_stat_t;
endpackage

// File: hdl/htbe_ctrl.sv
// ----------------------------------------------------------------------------
// htbe_ctrl
// Sequencer for count, build and encode operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module htbe_ctrl import htbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  htbe_stat_t stat_i,
  output htbe_cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:    state_d = stat_i.clr_last ? S_IDLE : S_CLR;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.op)
            OP_COUNT:  state_d = S_C_RD;
            OP_BUILD:  state_d = S_I_RD;
            OP_ENCODE: state_d = stat_i.tree_ready ? S_E_CNT : S_RES;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_C_RD:   state_d = S_C_WR;
      S_C_WR:   state_d = S_IDLE;
      S_I_RD:   state_d = S_I_WR;
      S_I_WR:   state_d = stat_i.init_last ? S_S_RD : S_I_RD;
      S_S_RD:   state_d = S_S_CMP;
      S_S_CMP:  state_d = stat_i.scan_last ? S_M_LO : S_S_RD;
      S_M_LO:   state_d = S_M_NX;
      S_M_NX:   state_d = stat_i.size_two ? S_ROOT : S_S_RD;
      S_ROOT:   state_d = S_RES;
      S_E_CNT:  state_d = S_E_CHK0;
      S_E_CHK0: state_d = (!stat_i.sym_ok || stat_i.cnt_zero) ? S_RES : S_E_CHK;
      S_E_CHK:  state_d = (stat_i.at_root || stat_i.len_full) ? S_RES : S_E_STEP;
      S_E_STEP: state_d = S_E_CHK;
      S_RES:    state_d = stat_i.out_free ? S_IDLE : S_RES;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_st = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      // count memory sweep after reset
      S_CLR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.take_in  = in_valid_i;
        cmd_o.init_start = in_valid_i && (stat_i.op == OP_BUILD);
        // encode without a tree answers at once
        cmd_o.res_set  = in_valid_i && (stat_i.op == OP_ENCODE) && !stat_i.tree_ready;
        cmd_o.res_st   = ST_NO_TREE;
      end
      S_C_RD: cmd_o.cnt_rd = 1'b1;
      S_C_WR: cmd_o.cnt_wr = 1'b1;
      S_I_RD: cmd_o.init_rd = 1'b1;
      S_I_WR: cmd_o.init_wr = 1'b1;
      S_S_RD: cmd_o.scan_rd = 1'b1;
      S_S_CMP: cmd_o.scan_cmp = 1'b1;
      S_M_LO: cmd_o.merge_lo = 1'b1;
      S_M_NX: cmd_o.merge_nx = 1'b1;
      S_ROOT: begin
        cmd_o.set_root = 1'b1;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_st   = ST_OK;
      end
      S_E_CNT: cmd_o.cnt_rd = 1'b1;
      S_E_CHK0: begin
        cmd_o.enc_start = 1'b1;
        cmd_o.res_set   = !stat_i.sym_ok || stat_i.cnt_zero;
        cmd_o.res_st    = ST_ZERO_CNT;
      end
      S_E_CHK: begin
        cmd_o.enc_rd  = 1'b1;
        cmd_o.res_set = stat_i.at_root || stat_i.len_full;
        cmd_o.res_st  = stat_i.at_root ? ST_OK : ST_TOO_LONG;
      end
      S_E_STEP: cmd_o.enc_step = 1'b1;
      S_RES:    cmd_o.res_load = stat_i.out_free;
      default: ;
    endcase
  end
endmodule

// File: hdl/htbe_dp.sv
// ----------------------------------------------------------------------------
// htbe_dp
// Count, slot and parent memories, min-pair scan and code walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "huffman_tree_build_encode_defines.svh"
module htbe_dp import htbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htbe_cmd_t           cmd_i,
  output htbe_stat_t          stat_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          sym_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BITS_W-1:0]   out_bits_o,
  output logic [LEN_W-1:0]    out_len_o,
  output logic [1:0]          out_st_o
);
  logic [COUNT_WIDTH-1:0]  cnt_mem [SYMBOLS];
  logic [NODE_W-1:0]       slot_n_mem [SYMBOLS];
  logic [WEIGHT_WIDTH-1:0] slot_w_mem [SYMBOLS];
  logic [NODE_W-1:0]       par_mem [NODE_TOTAL];
  logic                    left_mem [NODE_TOTAL];

  logic [COUNT_WIDTH-1:0]  cnt_rd_q;
  logic [NODE_W-1:0]       slot_n_rd_q, par_rd_q;
  logic [WEIGHT_WIDTH-1:0] slot_w_rd_q;
  logic                    left_rd_q;

  logic [SLOT_W-1:0]       clr_idx_q;
  logic [7:0]              sym_q;
  logic [IDX_W-1:0]        idx_q, size_q;
  logic [NODE_W-1:0]       merged_q;
  logic [SLOT_W-1:0]       lo_idx_q, nx_idx_q;
  logic [NODE_W-1:0]       lo_node_q, nx_node_q, last_node_q;
  logic [WEIGHT_WIDTH-1:0] lo_w_q, nx_w_q, last_w_q;
  logic [NODE_W-1:0]       n_q;
  logic [LEN_W-1:0]        len_q;
  logic [BITS_W-1:0]       bits_q;
  logic                    tree_ready_q;
  status_e                 res_st_q;
  logic                    res_ok_q;
  logic                    out_valid_q;
  logic [BITS_W-1:0]       out_bits_q;
  logic [LEN_W-1:0]        out_len_q;
  status_e                 out_st_q;

  logic [WEIGHT_WIDTH-1:0] wsum;
  logic [SLOT_W-1:0]       cnt_addr, slot_addr, scan_i;
  logic                    slot_we;
  logic [SLOT_W-1:0]       slot_wa;
  logic [NODE_W-1:0]       slot_wn;
  logic [WEIGHT_WIDTH-1:0] slot_ww;
  logic                    par_we;
  logic [NODE_W-1:0]       par_wa, par_wd;
  logic                    left_wd;
  logic                    sym_ok;

  assign wsum    = lo_w_q + nx_w_q;
  assign sym_ok  = {1'b0, sym_q} < 9'(SYMBOLS);
  assign scan_i  = idx_q[SLOT_W-1:0];
  assign cnt_addr  = cmd_i.init_rd ? scan_i : sym_q[SLOT_W-1:0];
  assign slot_addr = scan_i;

  // count memory
  always_ff @(posedge clk_i) begin
    cnt_rd_q <= cnt_mem[cnt_addr];
    if (cmd_i.clr_wr) begin
      cnt_mem[clr_idx_q] <= '0;
    end else if (cmd_i.cnt_wr && sym_ok && (cnt_rd_q != '1)) begin
      cnt_mem[sym_q[SLOT_W-1:0]] <= cnt_rd_q + 1'b1;
    end
  end

  // slot write mux
  always_comb begin
    slot_we = 1'b0;
    slot_wa = scan_i;
    slot_wn = NODE_W'(scan_i);
    slot_ww = WEIGHT_WIDTH'(cnt_rd_q);
    priority if (cmd_i.init_wr) begin
      slot_we = 1'b1;
    end else if (cmd_i.merge_lo) begin
      slot_we = 1'b1;
      slot_wa = lo_idx_q;
      slot_wn = merged_q;
      slot_ww = wsum;
    end else if (cmd_i.merge_nx) begin
      slot_we = 1'b1;
      slot_wa = nx_idx_q;
      // the last slot may just have taken the merged node
      if ({1'b0, lo_idx_q} == size_q - 1'b1) begin
        slot_wn = merged_q;
        slot_ww = wsum;
      end else begin
        slot_wn = last_node_q;
        slot_ww = last_w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_n_rd_q <= slot_n_mem[slot_addr];
    slot_w_rd_q <= slot_w_mem[slot_addr];
    if (slot_we) begin
      slot_n_mem[slot_wa] <= slot_wn;
      slot_w_mem[slot_wa] <= slot_ww;
    end
  end

  always_comb begin
    par_we  = cmd_i.merge_lo || cmd_i.merge_nx || cmd_i.set_root;
    par_wa  = cmd_i.merge_lo ? lo_node_q : nx_node_q;
    par_wd  = merged_q;
    left_wd = cmd_i.merge_lo;
    if (cmd_i.set_root) begin
      par_wa = NODE_W'(ROOT_NODE);
      par_wd = NODE_W'(ROOT_NODE);
    end
  end

  always_ff @(posedge clk_i) begin
    par_rd_q  <= par_mem[n_q];
    left_rd_q <= left_mem[n_q];
    if (par_we) begin
      par_mem[par_wa]  <= par_wd;
      left_mem[par_wa] <= left_wd;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      res_ok_q     <= 1'b0;
      clr_idx_q    <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_idx_q <= clr_idx_q + 1'b1;
      if (cmd_i.cnt_wr && sym_ok) tree_ready_q <= 1'b0;
      if (cmd_i.set_root) tree_ready_q <= 1'b1;
      if (cmd_i.res_set) res_ok_q <= (cmd_i.res_st == ST_OK) && cmd_i.enc_rd;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      sym_q <= sym_i;
    end
    if (cmd_i.init_start) idx_q <= '0;
    if (cmd_i.init_wr) begin
      idx_q  <= stat_o.init_last ? '0 : idx_q + 1'b1;
      size_q <= IDX_W'(SYMBOLS);
      merged_q <= NODE_W'(SYMBOLS);
    end
    if (cmd_i.scan_cmp) begin
      idx_q <= stat_o.scan_last ? '0 : idx_q + 1'b1;
      if (idx_q == '0) begin
        lo_idx_q  <= scan_i;
        lo_node_q <= slot_n_rd_q;
        lo_w_q    <= slot_w_rd_q;
      end else if (slot_w_rd_q < lo_w_q) begin
        nx_idx_q  <= lo_idx_q;
        nx_node_q <= lo_node_q;
        nx_w_q    <= lo_w_q;
        lo_idx_q  <= scan_i;
        lo_node_q <= slot_n_rd_q;
        lo_w_q    <= slot_w_rd_q;
      end else if ((idx_q == IDX_W'(1)) || (slot_w_rd_q < nx_w_q)) begin
        nx_idx_q  <= scan_i;
        nx_node_q <= slot_n_rd_q;
        nx_w_q    <= slot_w_rd_q;
      end
      if (stat_o.scan_last) begin
        last_node_q <= slot_n_rd_q;
        last_w_q    <= slot_w_rd_q;
      end
    end
    if (cmd_i.merge_nx) begin
      size_q   <= size_q - 1'b1;
      merged_q <= merged_q + 1'b1;
    end
    if (cmd_i.enc_start) begin
      n_q    <= NODE_W'(sym_q[SLOT_W-1:0]);
      len_q  <= '0;
      bits_q <= '0;
    end
    if (cmd_i.enc_step) begin
      n_q   <= par_rd_q;
      len_q <= len_q + 1'b1;
      if (left_rd_q) bits_q[len_q[5:0]] <= 1'b1;
    end
    if (cmd_i.res_set) res_st_q <= cmd_i.res_st;
    if (cmd_i.res_load) begin
      out_st_q   <= res_st_q;
      out_bits_q <= res_ok_q ? bits_q : '0;
      out_len_q  <= res_ok_q ? len_q : '0;
    end
  end

  always_comb begin
    stat_o.op         = op_e'(op_i);
    stat_o.tree_ready = tree_ready_q;
    stat_o.sym_ok     = sym_ok;
    stat_o.cnt_zero   = (cnt_rd_q == '0);
    stat_o.clr_last   = (clr_idx_q == SLOT_W'(SYMBOLS - 1));
    stat_o.init_last  = (idx_q == IDX_W'(SYMBOLS - 1));
    stat_o.scan_last  = (idx_q == size_q - 1'b1);
    stat_o.size_two   = (size_q == IDX_W'(2));
    stat_o.at_root    = (n_q == NODE_W'(ROOT_NODE));
    stat_o.len_full   = (len_q >= LEN_W'(MAX_CODE_LENGTH));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_bits_o  = out_bits_q;
  assign out_len_o   = out_len_q;
  assign out_st_o    = out_st_q;

  `HTBE_ASSERT_IMPL(a_err_zero, out_valid_q && (out_st_q != ST_OK), (out_len_q == '0) && (out_bits_q == '0))
  `HTBE_ASSERT_NEXT(a_ready_from_root, !tree_ready_q && !cmd_i.set_root, !tree_ready_q)
  `HTBE_ASSERT_IMPL(a_len_bound, cmd_i.enc_step, len_q < LEN_W'(MAX_CODE_LENGTH))
  `HTBE_ASSERT_IMPL(a_one_slot_write, 1'b1, $countones({cmd_i.init_wr, cmd_i.merge_lo, cmd_i.merge_nx}) <= 1)
endmodule

// File: hdl/huffman_tree_build_encode.sv
// Count: reads the symbol's counter, then writes it back incremented, saturating.
// Build: fills the slots, then rounds of min-pair scan over the live slots, each merging
// the two lightest. Encode: walks leaf to root, one parent-memory read per tree level.
// One item in flight; a new beat is taken while a result waits in the output register.
// Reset: tree marked not built, no result pending; then a sweep over every entry
// clears the count memory while s_axis_tready stays low.
// ----------------------------------------------------------------------------
// huffman_tree_build_encode
// Byte-alphabet Huffman counter, tree builder and encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module huffman_tree_build_encode import htbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] code_bits, [70:64] code_length
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  htbe_cmd_t         cmd;
  htbe_stat_t        stat;
  logic [BITS_W-1:0] bits;
  logic [LEN_W-1:0]  len;

  htbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  htbe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (s_axis_tuser),
    .sym_i       (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bits_o  (bits),
    .out_len_o   (len),
    .out_st_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, len, bits};
endmodule
